// ===== design/xcbc_pkg.sv =====
// Shared types, constants and round function for the XTEA CBC cipher.
package xcbc_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAINING_ENABLE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VECTOR  = 3'd6;

  typedef logic [3:0][31:0] key_t;

  // Block in flight plus the value XORed onto it at the exit.
  typedef struct packed {
    logic [63:0] block;
    logic [63:0] mask;
    logic        last;
  } cell_data_t;

  function automatic logic [31:0] xtea_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== design/xcbc_cell.sv =====
// One XTEA half round: a single cell of the cipher chain.
module xcbc_cell
  import xcbc_pkg::*;
#(
  parameter int STEP   = 0,
  parameter int ROUNDS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       encrypt,
  input  key_t       keys,
  input  logic       in_valid,
  input  cell_data_t in_data,
  output logic       out_valid,
  output cell_data_t out_data
);

  localparam int HALF = (STEP + 1) / 2;
  localparam logic [63:0] SUM_ENC_W = 64'(HALF) * 64'(XTEA_DELTA);
  localparam logic [63:0] SUM_DEC_W = 64'(ROUNDS - HALF) * 64'(XTEA_DELTA);
  localparam logic [31:0] SUM_ENC = SUM_ENC_W[31:0];
  localparam logic [31:0] SUM_DEC = SUM_DEC_W[31:0];
  // Encryption updates the upper word on even steps, decryption on odd ones.
  localparam logic ENC_UPD_V0 = ((STEP % 2) == 0);

  logic        upd_v0;
  logic [31:0] sum;
  logic [1:0]  kidx;
  logic [31:0] v0;
  logic [31:0] v1;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] f;
  logic [31:0] dst_next;
  cell_data_t  data_next;

  always_comb begin
    v0       = in_data.block[63:32];
    v1       = in_data.block[31:0];
    upd_v0   = encrypt ? ENC_UPD_V0 : !ENC_UPD_V0;
    sum      = encrypt ? SUM_ENC : SUM_DEC;
    kidx     = upd_v0 ? sum[1:0] : sum[12:11];
    src      = upd_v0 ? v1 : v0;
    dst      = upd_v0 ? v0 : v1;
    f        = xtea_mix(src) ^ (sum + keys[kidx]);
    dst_next = encrypt ? (dst + f) : (dst - f);
    data_next = in_data;
    if (upd_v0) begin
      data_next.block[63:32] = dst_next;
    end else begin
      data_next.block[31:0] = dst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/xtea_cbc_cipher_top.sv =====
// XTEA block cipher with optional CBC chaining, built as a chain of half-round cells.
//
// Requests enter on in_valid/in_ready with data_block, start_chain and last_block;
// results leave on out_valid/out_ready with result_block and result_last.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), used only
// while no request is in flight: key words 0..3, direction (1 encrypt), chaining
// enable, initial vector.
// Each request walks 2*ROUND_COUNT cells, one half round per cell, then an output
// register. ECB and CBC decryption take one request per cycle while the output is
// not stalled, since the chain value is the previous input block. CBC encryption
// feeds each result back into the next block, so a new request waits until the
// cell chain is empty.
// start_chain reloads the chain from the initial vector before its block.
// When out_valid is high and out_ready low the cell chain holds; the first cell
// still takes a request while it is empty. Reset clears the chain value, the keys,
// the vector and direction, sets chaining on and drops all requests in flight.
module xtea_cbc_cipher_top
  import xcbc_pkg::*;
#(
  parameter int ROUND_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [63:0]            data_block,
  input  logic                   start_chain,
  input  logic                   last_block,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            result_block,
  output logic                   result_last
);

  localparam int CELLS = 2 * ROUND_COUNT;

  key_t        keys;
  logic        direction;
  logic        chaining_enable;
  logic [63:0] initial_vector;
  logic [63:0] chain_value;

  logic       cell_valid [CELLS];
  cell_data_t cell_data  [CELLS];
  logic [CELLS-1:0] valid_vec;

  logic        advance;
  logic        busy;
  logic        enc_chain;
  logic        dec_chain;
  logic        in_fire;
  logic        out_load;
  logic [63:0] chain_sel;
  cell_data_t  entry;
  cell_data_t  tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys            <= '0;
      direction       <= 1'b0;
      chaining_enable <= 1'b1;
      initial_vector  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD_0:      keys[0]         <= cfg_data[31:0];
        REG_KEY_WORD_1:      keys[1]         <= cfg_data[31:0];
        REG_KEY_WORD_2:      keys[2]         <= cfg_data[31:0];
        REG_KEY_WORD_3:      keys[3]         <= cfg_data[31:0];
        REG_DIRECTION:       direction       <= cfg_data[0];
        REG_CHAINING_ENABLE: chaining_enable <= cfg_data[0];
        REG_INITIAL_VECTOR:  initial_vector  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      valid_vec[i] = cell_valid[i];
    end
  end

  assign enc_chain = chaining_enable && direction;
  assign dec_chain = chaining_enable && !direction;
  assign busy      = |valid_vec;
  assign advance   = !out_valid || out_ready;
  // Hold CBC encryption until the previous result has left the cells.
  assign in_ready  = (advance || !cell_valid[0]) && !(enc_chain && busy);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = advance && cell_valid[CELLS-1];
  assign chain_sel = start_chain ? initial_vector : chain_value;
  assign tail      = cell_data[CELLS-1];

  always_comb begin
    entry.block = enc_chain ? (data_block ^ chain_sel) : data_block;
    entry.mask  = dec_chain ? chain_sel : '0;
    entry.last  = last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
    end else begin
      if (in_fire) begin
        if (dec_chain) begin
          chain_value <= data_block;
        end else if (start_chain) begin
          chain_value <= initial_vector;
        end
      end
      if (out_load && enc_chain) begin
        chain_value <= tail.block;
      end
    end
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      xcbc_cell #(
        .STEP   (g),
        .ROUNDS (ROUND_COUNT)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (advance || !cell_valid[0]),
        .encrypt   (direction),
        .keys      (keys),
        .in_valid  (in_fire),
        .in_data   (entry),
        .out_valid (cell_valid[g]),
        .out_data  (cell_data[g])
      );
    end else begin : g_body
      xcbc_cell #(
        .STEP   (g),
        .ROUNDS (ROUND_COUNT)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (advance),
        .encrypt   (direction),
        .keys      (keys),
        .in_valid  (cell_valid[g-1]),
        .in_data   (cell_data[g-1]),
        .out_valid (cell_valid[g]),
        .out_data  (cell_data[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cell_valid[CELLS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_block <= tail.block ^ tail.mask;
      result_last  <= tail.last;
    end
  end

  a_enc_chain_alone: assert property (@(posedge clk) disable iff (rst)
    in_fire && enc_chain |-> !busy)
    else $error("CBC encryption request accepted with cells busy");

  a_enc_chain_feedback: assert property (@(posedge clk) disable iff (rst)
    out_load && enc_chain |=> chain_value == result_block)
    else $error("chain value does not follow the encrypted result");

  a_dec_chain_update: assert property (@(posedge clk) disable iff (rst)
    in_fire && dec_chain |=> chain_value == $past(data_block))
    else $error("chain value does not follow the decrypted input block");

  a_ecb_chain_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !chaining_enable && !start_chain |=> $stable(chain_value))
    else $error("chain value changed in ECB mode");

endmodule
